// ===== design/sed_pkg.sv =====
// Shared types and constants for the string escape decoder.
// Holds the transaction structs, the front-to-back command format and error codes.
// No dependencies.
package sed_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } char_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [2:0] error_code;
        logic       last;
    } res_item_t;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_END_ESCAPE  = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX     = 3'd2;
    localparam logic [2:0] ERR_BAD_UNICODE = 3'd3;
    localparam logic [2:0] ERR_RANGE       = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN     = 3'd5;

    // One decoded item: up to four result bytes, first byte in slot 0
    typedef struct packed {
        logic [3:0][7:0] byte_seq;
        logic [1:0]      last_idx;
        logic            has_byte;
        logic [2:0]      error_code;
    } sed_cmd_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

// ===== design/sed_front.sv =====
// Front end of the escape decoder: escape state machine and UTF-8 encoding.
// Turns each accepted transaction into at most one command for the queue.
// Depends on sed_pkg.
module sed_front
    import sed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  char_item_t item,
    output logic       cmd_valid,
    output sed_cmd_t   cmd
);

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_HEX,
        MODE_UNI
    } mode_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;

    mode_t       mode_reg,   mode_next;
    logic [3:0]  seen_reg,   seen_next;
    logic [3:0]  wanted_reg, wanted_next;
    logic [31:0] acc_reg,    acc_next;

    logic [7:0]  c;
    logic        eoi;
    logic        is_hex;
    logic [3:0]  digit;
    logic [8:0]  simple;
    logic [3:0]  seen_inc;
    logic [7:0]  acc8;
    logic [31:0] cp;

    // {hit, mapped byte} for the single-character escapes
    function automatic logic [8:0] simple_escape(input logic [7:0] ch);
        logic [8:0] r;
        case (ch)
            8'h6E:   r = {1'b1, 8'h0A};
            8'h74:   r = {1'b1, 8'h09};
            8'h72:   r = {1'b1, 8'h0D};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            8'h30:   r = {1'b1, 8'h00};
            8'h61:   r = {1'b1, 8'h07};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h76:   r = {1'b1, 8'h0B};
            default: r = {1'b0, 8'h00};
        endcase
        return r;
    endfunction

    function automatic sed_cmd_t one_result(input logic [7:0] b, input logic has,
                                            input logic [2:0] err);
        sed_cmd_t r;
        r = '0;
        r.byte_seq[0] = has ? b : 8'h00;
        r.has_byte    = has;
        r.error_code  = err;
        return r;
    endfunction

    function automatic sed_cmd_t encode_utf8(input logic [31:0] v);
        sed_cmd_t r;
        r = '0;
        r.has_byte = 1'b1;
        if (v <= 32'h7F) begin
            r.byte_seq[0] = v[7:0];
        end
        else if (v <= 32'h7FF) begin
            r.byte_seq[0] = 8'hC0 | {3'b000, v[10:6]};
            r.byte_seq[1] = 8'h80 | {2'b00, v[5:0]};
            r.last_idx    = 2'd1;
        end
        else if (v <= 32'hFFFF) begin
            r.byte_seq[0] = 8'hE0 | {4'h0, v[15:12]};
            r.byte_seq[1] = 8'h80 | {2'b00, v[11:6]};
            r.byte_seq[2] = 8'h80 | {2'b00, v[5:0]};
            r.last_idx    = 2'd2;
        end
        else if (v <= 32'h10FFFF) begin
            r.byte_seq[0] = 8'hF0 | {5'b00000, v[20:18]};
            r.byte_seq[1] = 8'h80 | {2'b00, v[17:12]};
            r.byte_seq[2] = 8'h80 | {2'b00, v[11:6]};
            r.byte_seq[3] = 8'h80 | {2'b00, v[5:0]};
            r.last_idx    = 2'd3;
        end
        else begin
            r.has_byte   = 1'b0;
            r.error_code = ERR_RANGE;
        end
        return r;
    endfunction

    always_comb
    begin
        c   = item.data_byte;
        eoi = item.end_of_input;

        is_hex = 1'b1;
        digit  = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            digit = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            digit = c[3:0] + 4'd9;
        end
        else begin
            is_hex = 1'b0;
        end
        if (eoi) begin
            is_hex = 1'b0;
        end

        simple   = simple_escape(c);
        seen_inc = seen_reg + 4'd1;
        acc8     = {acc_reg[3:0], digit};
        cp       = {acc_reg[27:0], digit};

        mode_next   = mode_reg;
        seen_next   = seen_reg;
        wanted_next = wanted_reg;
        acc_next    = acc_reg;
        cmd_valid   = 1'b0;
        cmd         = '0;

        case (mode_reg)
            MODE_NORMAL:
            begin
                if (!eoi) begin
                    if (c == CH_BSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end
                    else begin
                        cmd_valid = 1'b1;
                        cmd       = one_result(c, 1'b1, ERR_NONE);
                    end
                end
            end
            MODE_ESCAPE:
            begin
                mode_next   = MODE_NORMAL;
                seen_next   = 4'd0;
                wanted_next = 4'd0;
                acc_next    = 32'd0;
                if (eoi) begin
                    cmd_valid = 1'b1;
                    cmd       = one_result(8'h00, 1'b0, ERR_END_ESCAPE);
                end
                else if (simple[8]) begin
                    cmd_valid = 1'b1;
                    cmd       = one_result(simple[7:0], 1'b1, ERR_NONE);
                end
                else if (c == CH_X) begin
                    mode_next   = MODE_HEX;
                    wanted_next = 4'd2;
                end
                else if (c == CH_LOW_U || c == CH_UP_U) begin
                    mode_next   = MODE_UNI;
                    wanted_next = (c == CH_LOW_U) ? 4'd4 : 4'd8;
                end
                else begin
                    cmd_valid = 1'b1;
                    cmd       = one_result(c, 1'b1, ERR_UNKNOWN);
                end
            end
            MODE_HEX:
            begin
                if (is_hex && seen_reg == 4'd0) begin
                    seen_next = seen_inc;
                    acc_next  = {24'd0, acc8};
                end
                else begin
                    mode_next   = MODE_NORMAL;
                    seen_next   = 4'd0;
                    wanted_next = 4'd0;
                    acc_next    = 32'd0;
                    cmd_valid   = 1'b1;
                    if (is_hex) begin
                        cmd = one_result(acc8, 1'b1, ERR_NONE);
                    end
                    else if (seen_reg == 4'd0) begin
                        cmd = one_result(8'h00, 1'b0, ERR_BAD_HEX);
                    end
                    else begin
                        // one-digit value, then the ending byte taken as a fresh one
                        cmd = one_result(acc_reg[7:0], 1'b1, ERR_NONE);
                        if (!eoi) begin
                            if (c == CH_BSLASH) begin
                                mode_next = MODE_ESCAPE;
                            end
                            else begin
                                cmd.byte_seq[1] = c;
                                cmd.last_idx    = 2'd1;
                            end
                        end
                    end
                end
            end
            MODE_UNI:
            begin
                if (is_hex && seen_inc < wanted_reg) begin
                    seen_next = seen_inc;
                    acc_next  = cp;
                end
                else begin
                    mode_next   = MODE_NORMAL;
                    seen_next   = 4'd0;
                    wanted_next = 4'd0;
                    acc_next    = 32'd0;
                    cmd_valid   = 1'b1;
                    cmd = is_hex ? encode_utf8(cp)
                                 : one_result(8'h00, 1'b0, ERR_BAD_UNICODE);
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
            end
        endcase

        if (!accept) begin
            cmd_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_NORMAL;
            seen_reg   <= 4'd0;
            wanted_reg <= 4'd0;
            acc_reg    <= 32'd0;
        end
        else if (accept) begin
            mode_reg   <= mode_next;
            seen_reg   <= seen_next;
            wanted_reg <= wanted_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

// ===== design/sed_queue.sv =====
// Command queue between the decoder front end and the result sequencer.
// Small register-file FIFO of sed_cmd_t entries.
// Depends on sed_pkg.
module sed_queue
    import sed_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sed_cmd_t push_data,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output sed_cmd_t head
);

    sed_cmd_t                queue_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg;
    logic [QUEUE_AW-1:0]     rd_ptr_reg;
    logic [QUEUE_AW:0]       count_reg;

    assign full      = (count_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = queue_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            queue_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            end
            else if (pop && !push) begin
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + (QUEUE_AW+1)'(1)))
        else $error("queue count did not advance on push");

endmodule

// ===== design/sed_back.sv =====
// Result sequencer: walks each queued command one byte per cycle into a
// registered result port, pausing while res_stall holds it. Depends on sed_pkg.
module sed_back
    import sed_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_not_empty,
    input  sed_cmd_t  q_head,
    output logic      q_pop,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_data
);

    logic      cmd_valid_reg;
    sed_cmd_t  cmd_reg;
    logic [1:0] idx_reg;
    logic      out_valid_reg;
    res_item_t out_reg;

    logic      slot_free;
    logic      emit;
    logic      cmd_done;
    res_item_t res_next;

    assign slot_free = !out_valid_reg || !res_stall;
    assign emit      = cmd_valid_reg && slot_free;
    assign cmd_done  = (idx_reg == cmd_reg.last_idx);
    assign q_pop     = q_not_empty && (!cmd_valid_reg || (emit && cmd_done));

    always_comb
    begin
        res_next.out_byte   = cmd_reg.byte_seq[idx_reg];
        res_next.has_byte   = cmd_reg.has_byte;
        res_next.error_code = cmd_reg.error_code;
        res_next.last       = cmd_done;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            cmd_reg <= q_head;
        end
        if (emit) begin
            out_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (q_pop) begin
                cmd_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (emit) begin
                if (cmd_done) begin
                    cmd_valid_reg <= 1'b0;
                end
                else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end

            if (emit) begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg |-> (idx_reg <= cmd_reg.last_idx))
        else $error("result index beyond command length");

endmodule

// ===== design/string_escape_decoder_utf8.sv =====
// Top level of the string escape decoder with UTF-8 output.
// Joins sed_front, sed_queue and sed_back. Depends on sed_pkg.
//
// One input byte is taken per clock while the four-entry command queue has
// room; the front end decides each byte in the cycle it is accepted. Results
// leave one per clock from a registered port while res_stall is low; an
// item yielding k results (0 to 4, e.g. a four-byte UTF-8 sequence) holds
// the port until all k have left. Without output stalls, throughput is one
// input byte per cycle for text that yields at most one result per byte, and
// one result per cycle otherwise. A byte's first result passes the queue,
// cmd_reg and out_reg. char_stall rises only when the command queue is full.
module string_escape_decoder_utf8
    import sed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  char_item_t char_data,
    output logic       res_valid,
    input  logic       res_stall,
    output res_item_t  res_data
);

    logic     accept;
    logic     cmd_valid;
    sed_cmd_t cmd;
    logic     q_full;
    logic     q_not_empty;
    logic     q_pop;
    sed_cmd_t q_head;

    assign char_stall = q_full;
    assign accept     = char_valid && !char_stall;

    sed_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (char_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    sed_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid),
        .push_data (cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    sed_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for string_escape_decoder_utf8: directed table, then random escape
// sequences, each result checked against typed-in values or an in-bench decoder with UTF-8 encoding.
// Depends on sed_pkg and the design files only.
module tb_top;
    import sed_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_ITEMS = 240;
    localparam int TAIL_START = 200;

    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_N    = "n";
    localparam logic [7:0] CH_T    = "t";
    localparam logic [7:0] CH_R    = "r";
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_A    = "a";
    localparam logic [7:0] CH_B    = "b";
    localparam logic [7:0] CH_F    = "f";
    localparam logic [7:0] CH_V    = "v";
    localparam logic [7:0] CH_X    = "x";
    localparam logic [7:0] CH_U    = "u";
    localparam logic [7:0] CH_UU   = "U";

    typedef enum logic [1:0] {DEC_PLAIN, DEC_ESCAPE, DEC_HEX, DEC_UNICODE} dec_mode_t;

    // one directed transaction; the expected result is typed in when 'typed' is set
    typedef struct packed {
        logic [7:0] data_byte;
        logic       eoi;
        logic       typed;
        logic [7:0] out_byte;
        logic       has_byte;
        logic [2:0] err;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       char_valid;
    logic       char_stall;
    char_item_t char_data;
    logic       res_valid;
    logic       res_stall;
    res_item_t  res_data;

    string_escape_decoder_utf8 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    // decoder state held by the bench
    dec_mode_t   dec_mode;
    logic [3:0]  n_digits;
    logic [3:0]  n_wanted;
    logic [31:0] acc_value;

    res_item_t  decoded_now[$];
    res_item_t  pending_results[$];
    char_item_t seq_q[$];

    logic [7:0] simple_chars [11] = '{CH_N, CH_T, CH_R, CH_BSL, CH_SQ, CH_DQ, CH_ZERO,
                                      CH_A, CH_B, CH_F, CH_V};

    dir_row_t dir_rows [29] = '{
        '{8'h00,   1'b0, 1'b1, 8'h00, 1'b1, ERR_NONE},
        '{8'hFF,   1'b0, 1'b1, 8'hFF, 1'b1, ERR_NONE},
        '{8'hFF,   1'b1, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{CH_BSL,  1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{CH_N,    1'b0, 1'b1, 8'h0A, 1'b1, ERR_NONE},
        '{CH_BSL,  1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{8'h00,   1'b1, 1'b1, 8'h00, 1'b0, ERR_END_ESCAPE},
        '{CH_BSL,  1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{"q",     1'b0, 1'b1, "q",   1'b1, ERR_UNKNOWN},
        '{CH_BSL,  1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{CH_X,    1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{"g",     1'b0, 1'b1, 8'h00, 1'b0, ERR_BAD_HEX},
        '{CH_BSL,  1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{CH_X,    1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{"F",     1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{8'h00,   1'b1, 1'b1, 8'h0F, 1'b1, ERR_NONE},
        '{CH_BSL,  1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{CH_UU,   1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{"0",     1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{"0",     1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{"1",     1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{"1",     1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{"0",     1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{"0",     1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{"0",     1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{"0",     1'b0, 1'b1, 8'h00, 1'b0, ERR_RANGE},
        '{CH_BSL,  1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{CH_U,    1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE},
        '{"Z",     1'b0, 1'b1, 8'h00, 1'b0, ERR_BAD_UNICODE}
    };

    int  n_items;
    int  n_checked;
    int  n_errors;
    int  n_input_stalls = 0;
    int  cycle_count = 0;
    bit  gaps_on;
    bit  stall_on;
    bit  long_hold;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (char_valid && char_stall)
            n_input_stalls <= n_input_stalls + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- decoder
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    task automatic add_result(input logic [7:0] b, input logic has, input logic [2:0] err);
        res_item_t r;
        r.out_byte   = has ? b : 8'h00;
        r.has_byte   = has;
        r.error_code = err;
        r.last       = 1'b0;
        decoded_now.insert(decoded_now.size(), r);
    endtask

    task automatic clear_escape();
        dec_mode  = DEC_PLAIN;
        n_digits  = 4'd0;
        n_wanted  = 4'd0;
        acc_value = 32'd0;
    endtask

    task automatic plain_char(input logic [7:0] c);
        if (c == CH_BSL)
            dec_mode = DEC_ESCAPE;
        else
            add_result(c, 1'b1, ERR_NONE);
    endtask

    task automatic emit_utf8(input logic [31:0] cp);
        if (cp <= 32'h7F)
            add_result(cp[7:0], 1'b1, ERR_NONE);
        else if (cp <= 32'h7FF)
        begin
            add_result(8'hC0 | 8'(cp >> 6), 1'b1, ERR_NONE);
            add_result(8'h80 | 8'(cp & 32'h3F), 1'b1, ERR_NONE);
        end
        else if (cp <= 32'hFFFF)
        begin
            add_result(8'hE0 | 8'(cp >> 12), 1'b1, ERR_NONE);
            add_result(8'h80 | 8'((cp >> 6) & 32'h3F), 1'b1, ERR_NONE);
            add_result(8'h80 | 8'(cp & 32'h3F), 1'b1, ERR_NONE);
        end
        else if (cp <= 32'h10FFFF)
        begin
            add_result(8'hF0 | 8'(cp >> 18), 1'b1, ERR_NONE);
            add_result(8'h80 | 8'((cp >> 12) & 32'h3F), 1'b1, ERR_NONE);
            add_result(8'h80 | 8'((cp >> 6) & 32'h3F), 1'b1, ERR_NONE);
            add_result(8'h80 | 8'(cp & 32'h3F), 1'b1, ERR_NONE);
        end
        else
            add_result(8'h00, 1'b0, ERR_RANGE);
    endtask

    task automatic escape_char(input logic [7:0] c);
        logic [7:0] mapped;
        bit         simple;
        simple = 1'b1;
        case (c)
            CH_N:    mapped = 8'h0A;
            CH_T:    mapped = 8'h09;
            CH_R:    mapped = 8'h0D;
            CH_BSL:  mapped = CH_BSL;
            CH_SQ:   mapped = CH_SQ;
            CH_DQ:   mapped = CH_DQ;
            CH_ZERO: mapped = 8'h00;
            CH_A:    mapped = 8'h07;
            CH_B:    mapped = 8'h08;
            CH_F:    mapped = 8'h0C;
            CH_V:    mapped = 8'h0B;
            default:
            begin
                mapped = 8'h00;
                simple = 1'b0;
            end
        endcase
        if (simple)
        begin
            add_result(mapped, 1'b1, ERR_NONE);
            clear_escape();
        end
        else if (c == CH_X || c == CH_U || c == CH_UU)
        begin
            dec_mode  = (c == CH_X) ? DEC_HEX : DEC_UNICODE;
            n_wanted  = (c == CH_X) ? 4'd2 : ((c == CH_U) ? 4'd4 : 4'd8);
            n_digits  = 4'd0;
            acc_value = 32'd0;
        end
        else
        begin
            add_result(c, 1'b1, ERR_UNKNOWN);
            clear_escape();
        end
    endtask

    // works out the results of one accepted transaction into decoded_now
    task automatic decode_char(input char_item_t item);
        logic [7:0]  c;
        logic [31:0] cp;
        bit          eoi;
        int          d;
        c   = item.data_byte;
        eoi = item.end_of_input;
        decoded_now.delete();
        case (dec_mode)
            DEC_PLAIN:
                if (!eoi) plain_char(c);
            DEC_ESCAPE:
                if (eoi)
                begin
                    add_result(8'h00, 1'b0, ERR_END_ESCAPE);
                    clear_escape();
                end
                else
                    escape_char(c);
            DEC_HEX:
            begin
                d = eoi ? -1 : hex_nibble(c);
                if (d >= 0)
                begin
                    acc_value = ((acc_value << 4) | 32'(d)) & 32'hFF;
                    n_digits  = n_digits + 4'd1;
                    if (n_digits >= 4'd2)
                    begin
                        add_result(acc_value[7:0], 1'b1, ERR_NONE);
                        clear_escape();
                    end
                end
                else if (n_digits == 4'd0)
                begin
                    add_result(8'h00, 1'b0, ERR_BAD_HEX);
                    clear_escape();
                end
                else
                begin
                    // one-digit value, then the byte is taken afresh
                    add_result(acc_value[7:0], 1'b1, ERR_NONE);
                    clear_escape();
                    if (!eoi) plain_char(c);
                end
            end
            default:
            begin
                d = eoi ? -1 : hex_nibble(c);
                if (d >= 0)
                begin
                    acc_value = (acc_value << 4) | 32'(d);
                    n_digits  = n_digits + 4'd1;
                    if (n_digits >= n_wanted)
                    begin
                        cp = acc_value;
                        clear_escape();
                        emit_utf8(cp);
                    end
                end
                else
                begin
                    add_result(8'h00, 1'b0, ERR_BAD_UNICODE);
                    clear_escape();
                end
            end
        endcase
        if (decoded_now.size() > 0)
            decoded_now[decoded_now.size() - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------- stimulus
    function automatic logic [7:0] hex_ascii(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return "0" + {4'h0, v};
        return (upper ? "A" : "a") + {4'h0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (hex_nibble(b) >= 0);
        return b;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        char_item_t it;
        it.data_byte    = b;
        it.end_of_input = 1'b0;
        seq_q.insert(seq_q.size(), it);
    endtask

    task automatic push_eoi();
        char_item_t it;
        it.data_byte    = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        seq_q.insert(seq_q.size(), it);
    endtask

    task automatic push_digits(input logic [31:0] v, input int count);
        for (int i = count - 1; i >= 0; i--)
            push_byte(hex_ascii(v[4*i +: 4], 1'($urandom_range(0, 1))));
    endtask

    // a non-hex byte or end of input; a backslash gets an n so it closes cleanly
    task automatic push_terminator();
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0)
            push_eoi();
        else
        begin
            b = rand_non_hex();
            push_byte(b);
            if (b == CH_BSL) push_byte(CH_N);
        end
    endtask

    function automatic logic [31:0] rand_codepoint(input bit wide);
        case ($urandom_range(0, wide ? 4 : 2))
            0:       return $urandom_range(0, 32'h7F);
            1:       return $urandom_range(32'h80, 32'h7FF);
            2:       return $urandom_range(32'h800, 32'hFFFF);
            3:       return $urandom_range(32'h10000, 32'h10FFFF);
            default: return $urandom_range(32'h110000, 32'hFFFFFFFF);
        endcase
    endfunction

    task automatic make_sequence();
        int         kind;
        int         nd;
        logic [7:0] b;
        bit         wide;
        seq_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 22)
        begin
            repeat ($urandom_range(1, 3))
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_BSL);
                push_byte(b);
            end
        end
        else if (kind < 37)
        begin
            push_byte(CH_BSL);
            push_byte(simple_chars[$urandom_range(0, 10)]);
        end
        else if (kind < 47)
        begin
            push_byte(CH_BSL);
            push_byte(CH_X);
            push_digits($urandom_range(0, 255), 2);
        end
        else if (kind < 53)
        begin
            // short hex escape: none or one digit, then a terminator
            push_byte(CH_BSL);
            push_byte(CH_X);
            nd = $urandom_range(0, 1);
            push_digits($urandom_range(0, 15), nd);
            push_terminator();
        end
        else if (kind < 83)
        begin
            wide = (kind >= 68);
            push_byte(CH_BSL);
            push_byte(wide ? CH_UU : CH_U);
            push_digits(rand_codepoint(wide), wide ? 8 : 4);
        end
        else if (kind < 90)
        begin
            wide = 1'($urandom_range(0, 1));
            push_byte(CH_BSL);
            push_byte(wide ? CH_UU : CH_U);
            push_digits($urandom, $urandom_range(0, wide ? 7 : 3));
            push_terminator();
        end
        else if (kind < 94)
        begin
            push_byte(CH_BSL);
            push_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 96)
        begin
            push_byte(CH_BSL);
            push_eoi();
        end
        else if ($urandom_range(0, 1) == 0)
            push_eoi();
        else
            push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_char(input char_item_t item, input bit typed, input res_item_t want);
        int gap;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            char_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= item;
        @(posedge clk);
        while (char_stall) @(posedge clk);
        // an end of input in plain mode does nothing, so it is not counted
        if (!(item.end_of_input && dec_mode == DEC_PLAIN))
            n_items++;
        decode_char(item);
        if (typed)
            pending_results.insert(pending_results.size(), want);
        else
            foreach (decoded_now[i])
                pending_results.insert(pending_results.size(), decoded_now[i]);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        char_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- result side
    initial
    begin : res_stall_gen
        int burst;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
                res_stall <= 1'b0;
            end
            else if (stall_on && $urandom_range(0, 7) == 0)
            begin
                res_stall <= 1'b1;
                burst = $urandom_range(1, 11);
                repeat (burst) @(negedge clk);
                res_stall <= 1'b0;
            end
            else
                res_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string field, input int want, input int got);
        n_errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got %p", $time, res_data);
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (res_data.out_byte !== want.out_byte)
                    report_mismatch("out_byte", want.out_byte, res_data.out_byte);
                if (res_data.has_byte !== want.has_byte)
                    report_mismatch("has_byte", want.has_byte, res_data.has_byte);
                if (res_data.error_code !== want.error_code)
                    report_mismatch("error_code", want.error_code, res_data.error_code);
                if (res_data.last !== want.last)
                    report_mismatch("last", want.last, res_data.last);
            end
        end
    end

    // ---------------------------------------------------------------- main
    initial
    begin
        res_item_t want;
        char_item_t it;
        int n_directed;
        int n_random;
        bit hold_done;
        bit pause_done;
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_data  = '0;
        gaps_on    = 1'b1;
        stall_on   = 1'b1;
        long_hold  = 1'b0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        n_items    = 0;
        n_checked  = 0;
        n_errors   = 0;
        clear_escape();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            it.data_byte    = dir_rows[i].data_byte;
            it.end_of_input = dir_rows[i].eoi;
            want = '{dir_rows[i].out_byte, dir_rows[i].has_byte, dir_rows[i].err, 1'b1};
            send_char(it, dir_rows[i].typed, want);
        end
        n_directed = n_items;
        wait_drained();

        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            if (n_random >= 90 && !hold_done)
            begin
                // results held back while bytes keep coming, so the queue fills
                long_hold = 1'b1;
                hold_done = 1'b1;
            end
            if (n_random >= 170 && !pause_done)
            begin
                wait_drained();
                pause_done = 1'b1;
            end
            stall_on = (n_random < TAIL_START);
            gaps_on  = (n_random < TAIL_START) && !long_hold;
            make_sequence();
            foreach (seq_q[i]) send_char(seq_q[i], 1'b0, '0);
            n_random = n_items - n_directed;
        end
        @(negedge clk);
        char_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d transactions in (%0d directed), %0d results checked, %0d mismatches",
                 n_items, n_directed, n_checked, n_errors);
        $display("input held back on %0d cycles; long output hold-off and full drain done",
                 n_input_stalls);
        if (n_errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
